/* sv/evf_pkg.sv */
// ----------------------------------------------------------------------------
// evf_pkg: shared types and constants for the event FIFO
// Sizes, command and register codes, and the structs that pass between the
// configuration, ring storage and admission modules.
// ----------------------------------------------------------------------------
package evf_pkg;

  localparam int DEPTH      = 16;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int TICKET_W   = 32;
  localparam int PAYLOAD_W  = 32;
  localparam int CODE_W     = 8;
  localparam int SIZE_W     = 7;
  localparam int REM_W      = 6;
  localparam int OVF_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [REM_W-1:0] REM_MAX = '1;

  // Command codes
  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FAILED_TYPE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_FULL     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INVALID_TICKET = 2'd2;

  typedef struct packed {
    logic [TICKET_W-1:0]  ticket;
    logic [CODE_W-1:0]    etype;
    logic [CODE_W-1:0]    failure;
    logic [PAYLOAD_W-1:0] payload;
  } event_t;

  typedef struct packed {
    logic              command;
    logic              first;
    logic [SIZE_W-1:0] size;
    event_t            ev;
  } request_t;

  typedef struct packed {
    logic                ok;
    event_t              ev;
    logic [CNT_W-1:0]    fill;
    logic [CNT_W-1:0]    free;
    logic                fault_pending;
    logic [OVF_W-1:0]    overflows;
    logic [TICKET_W-1:0] last_bad;
  } result_t;

  typedef struct packed {
    logic [CODE_W-1:0]   failed_type;
    logic [CODE_W-1:0]   queue_full;
    logic                invalid_load;
    logic [TICKET_W-1:0] invalid_ticket;
  } cfg_t;

  typedef struct packed {
    logic   push;
    logic   pop;
    event_t wr_ev;
  } ring_ctrl_t;

endpackage

/* sv/evf_cfg.sv */
// ----------------------------------------------------------------------------
// evf_cfg: configuration registers
// Holds the fault record codes and flags a write of the invalid ticket.
// ----------------------------------------------------------------------------
module evf_cfg import evf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  logic [CODE_W-1:0] failed_type;
  logic [CODE_W-1:0] queue_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      failed_type <= '0;
      queue_full  <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FAILED_TYPE: failed_type <= cfg_data[CODE_W-1:0];
        REG_QUEUE_FULL:  queue_full  <= cfg_data[CODE_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.failed_type    = failed_type;
  assign cfg.queue_full     = queue_full;
  assign cfg.invalid_load   = cfg_write && (cfg_index == REG_INVALID_TICKET);
  assign cfg.invalid_ticket = cfg_data[TICKET_W-1:0];

endmodule

/* sv/evf_ring.sv */
// ----------------------------------------------------------------------------
// evf_ring: circular event storage
// Slot array with head pointer and fill count; one push or one pop a cycle.
// ----------------------------------------------------------------------------
module evf_ring import evf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  ring_ctrl_t       ctrl,
  output event_t           head_ev,
  output logic [CNT_W-1:0] count
);

  event_t           slots [DEPTH];
  logic [IDX_W-1:0] head;
  logic [IDX_W:0]   tail_sum;
  logic [IDX_W-1:0] tail;

  // Tail wraps past the end of the array
  always_comb begin
    tail_sum = (IDX_W + 1)'(head) + (IDX_W + 1)'(count);
    if (tail_sum >= (IDX_W + 1)'(DEPTH)) begin
      tail_sum = tail_sum - (IDX_W + 1)'(DEPTH);
    end
    tail = tail_sum[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      slots[tail] <= ctrl.wr_ev;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      count <= '0;
    end else if (ctrl.push) begin
      count <= count + CNT_W'(1);
    end else if (ctrl.pop) begin
      head  <= (head == IDX_W'(DEPTH - 1)) ? '0 : head + IDX_W'(1);
      count <= count - CNT_W'(1);
    end
  end

  assign head_ev = slots[head];

endmodule

/* sv/evf_admit.sv */
// ----------------------------------------------------------------------------
// evf_admit: batch admission and fault bookkeeping
// Judges each command against the ring state, keeps the fault record,
// overflow count and batch progress, and forms the result word.
// ----------------------------------------------------------------------------
module evf_admit import evf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  request_t         req,
  input  cfg_t             cfg,
  input  event_t           head_ev,
  input  logic [CNT_W-1:0] count,
  output ring_ctrl_t       ring_ctrl,
  output result_t          res
);

  logic                fault_flag, fault_flag_next;
  event_t              fault_ev, fault_ev_next;
  logic [OVF_W-1:0]    overflows, overflows_next;
  logic [TICKET_W-1:0] last_bad, last_bad_next;
  logic [REM_W-1:0]    remaining, remaining_next;
  logic                dropping, dropping_next;

  logic [CNT_W-1:0]    free_now;
  logic [SIZE_W-1:0]   size_m1;
  logic [REM_W-1:0]    rest;
  logic [CNT_W-1:0]    count_after;
  logic                ok;
  event_t              out_ev;

  assign free_now = CNT_W'(DEPTH) - count;
  assign size_m1  = req.size - SIZE_W'(1);
  assign rest     = (size_m1 > SIZE_W'(REM_MAX)) ? REM_MAX : size_m1[REM_W-1:0];

  always_comb begin
    fault_flag_next = fault_flag;
    fault_ev_next   = fault_ev;
    overflows_next  = overflows;
    last_bad_next   = last_bad;
    remaining_next  = remaining;
    dropping_next   = dropping;
    ring_ctrl.push  = 1'b0;
    ring_ctrl.pop   = 1'b0;
    ring_ctrl.wr_ev = req.ev;
    ok              = 1'b0;
    out_ev          = '0;
    if (req_valid) begin
      if (req.command == CMD_PUSH) begin
        if (req.first) begin
          priority if (req.size == '0) begin
            ok             = 1'b1;
            remaining_next = '0;
            dropping_next  = 1'b0;
          end else if (fault_flag && (req.ev.ticket == fault_ev.ticket)) begin
            overflows_next = overflows + OVF_W'(1);
            last_bad_next  = req.ev.ticket;
            remaining_next = rest;
            dropping_next  = 1'b1;
          end else if (req.size > SIZE_W'(free_now)) begin
            overflows_next = overflows + OVF_W'(1);
            last_bad_next  = req.ev.ticket;
            remaining_next = rest;
            dropping_next  = 1'b1;
            if (!fault_flag) begin
              fault_flag_next       = 1'b1;
              fault_ev_next.ticket  = req.ev.ticket;
              fault_ev_next.etype   = cfg.failed_type;
              fault_ev_next.failure = cfg.queue_full;
              fault_ev_next.payload = req.ev.payload;
            end
          end else begin
            ring_ctrl.push = 1'b1;
            ok             = 1'b1;
            remaining_next = rest;
            dropping_next  = 1'b0;
          end
        end else if (remaining != '0) begin
          remaining_next = remaining - REM_W'(1);
          if (!dropping && (count < CNT_W'(DEPTH))) begin
            ring_ctrl.push = 1'b1;
            ok             = 1'b1;
          end
        end
      end else begin
        if (count != '0) begin
          ring_ctrl.pop = 1'b1;
          ok            = 1'b1;
          out_ev        = head_ev;
        end else if (fault_flag) begin
          ok              = 1'b1;
          out_ev          = fault_ev;
          fault_flag_next = 1'b0;
          fault_ev_next   = '0;
        end
      end
    end
  end

  assign count_after = count + CNT_W'(ring_ctrl.push) - CNT_W'(ring_ctrl.pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      fault_flag <= 1'b0;
      fault_ev   <= '0;
      overflows  <= '0;
      last_bad   <= '0;
      remaining  <= '0;
      dropping   <= 1'b0;
    end else begin
      fault_flag <= fault_flag_next;
      fault_ev   <= fault_ev_next;
      overflows  <= overflows_next;
      remaining  <= remaining_next;
      dropping   <= dropping_next;
      // A new invalid ticket stands in for the reset value until the first overflow
      if (cfg.invalid_load && (overflows == '0)) begin
        last_bad <= cfg.invalid_ticket;
      end else begin
        last_bad <= last_bad_next;
      end
    end
  end

  assign res.ok            = ok;
  assign res.ev            = out_ev;
  assign res.fill          = count_after;
  assign res.free          = CNT_W'(DEPTH) - count_after;
  assign res.fault_pending = fault_flag_next;
  assign res.overflows     = overflows_next;
  assign res.last_bad      = last_bad_next;

endmodule

/* sv/event_fifo_batch_admit_overflow.sv */
// ----------------------------------------------------------------------------
// event_fifo_batch_admit_overflow: event FIFO with batch admission
// Sixteen-entry event queue that admits push batches all or nothing and keeps
// an overflow fault record that is popped once the queue runs empty.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: drive command, batch_first, batch_size and the event
//   fields, and raise start. A word is taken at each rising edge where start
//   is high and busy is low; busy never rises, so a word may be sent in
//   every cycle.
//   Result channel: done pulses for one cycle with one result word per
//   command: ok, the popped event (zero unless a pop delivered one), fill
//   and free counts, fault status, overflow count and last rejected ticket.
//   Timing: the word is registered at the accepting edge and judged against
//   the queue in the next cycle; done and the result appear in the cycle
//   after that, from the result register. Throughput is one word per cycle,
//   set by the single read and write of the slot array per cycle.
//   The receiver cannot hold results off, so no result is ever stalled.
//   Configuration: cfg_write with cfg_index and cfg_data writes one register
//   at an edge: fault type code, fault failure code, invalid ticket. Write
//   only while no command is in flight.
//   Reset (rst, synchronous): empties the queue, clears the fault record,
//   overflow count and batch progress, and sets last ticket to zero.
// ----------------------------------------------------------------------------
module event_fifo_batch_admit_overflow import evf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // command channel
  input  logic                  start,
  output logic                  busy,
  input  logic                  command,
  input  logic                  batch_first,
  input  logic [SIZE_W-1:0]     batch_size,
  input  logic [TICKET_W-1:0]   ticket,
  input  logic [CODE_W-1:0]     event_type,
  input  logic [CODE_W-1:0]     failure_code,
  input  logic [PAYLOAD_W-1:0]  payload,
  // configuration port
  input  logic                  cfg_write,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  // result channel
  output logic                  done,
  output logic                  ok,
  output logic [TICKET_W-1:0]   out_ticket,
  output logic [CODE_W-1:0]     out_type,
  output logic [CODE_W-1:0]     out_failure,
  output logic [PAYLOAD_W-1:0]  out_payload,
  output logic [CNT_W-1:0]      fill_count,
  output logic [CNT_W-1:0]      free_slots,
  output logic                  fault_pending,
  output logic [OVF_W-1:0]      overflows_seen,
  output logic [TICKET_W-1:0]   last_bad_ticket
);

  cfg_t       cfg;
  logic       req_valid;
  request_t   req;
  ring_ctrl_t ring_ctrl;
  event_t     head_ev;
  logic [CNT_W-1:0] count;
  result_t    res_next;
  result_t    res;

  // Every word is taken in the cycle it arrives
  assign busy = 1'b0;

  // Input register: hold the command word while the admission logic judges it
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req.command    <= command;
      req.first      <= batch_first;
      req.size       <= batch_size;
      req.ev.ticket  <= ticket;
      req.ev.etype   <= event_type;
      req.ev.failure <= failure_code;
      req.ev.payload <= payload;
    end
  end

  evf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  evf_ring u_ring (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (ring_ctrl),
    .head_ev (head_ev),
    .count   (count)
  );

  evf_admit u_admit (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req       (req),
    .cfg       (cfg),
    .head_ev   (head_ev),
    .count     (count),
    .ring_ctrl (ring_ctrl),
    .res       (res_next)
  );

  // Result register: advance one word per judged command, strobe with done
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid) begin
      res <= res_next;
    end
  end

  assign ok              = res.ok;
  assign out_ticket      = res.ev.ticket;
  assign out_type        = res.ev.etype;
  assign out_failure     = res.ev.failure;
  assign out_payload     = res.ev.payload;
  assign fill_count      = res.fill;
  assign free_slots      = res.free;
  assign fault_pending   = res.fault_pending;
  assign overflows_seen  = res.overflows;
  assign last_bad_ticket = res.last_bad;

endmodule

/* sv/evf_checker.sv */
// ----------------------------------------------------------------------------
// evf_checker: port-level checks for the event FIFO
// Watches the command and result channels of the top level.
// ----------------------------------------------------------------------------
module evf_checker import evf_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  start,
  input logic                  busy,
  input logic                  done,
  input logic                  ok,
  input logic [TICKET_W-1:0]   out_ticket,
  input logic [CODE_W-1:0]     out_type,
  input logic [CODE_W-1:0]     out_failure,
  input logic [PAYLOAD_W-1:0]  out_payload,
  input logic [CNT_W-1:0]      fill_count,
  input logic [CNT_W-1:0]      free_slots,
  input logic [OVF_W-1:0]      overflows_seen
);

  // Every accepted word yields a result through the input and result registers
  a_one_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted word produced no result");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> ##1 !done)
    else $error("result without an accepted word");

  // Fill and free counts of every result add up to the depth
  a_counts: assert property (@(posedge clk) disable iff (rst)
    done |-> ((fill_count + free_slots) == CNT_W'(DEPTH)))
    else $error("fill and free counts disagree");

  // A word that delivers nothing carries a zero event
  a_zero_event: assert property (@(posedge clk) disable iff (rst)
    (done && !ok) |-> (out_ticket == '0 && out_type == '0 &&
                       out_failure == '0 && out_payload == '0))
    else $error("event fields set on a result without delivery");

  // Consecutive results move the overflow count by at most one
  a_ovf_step: assert property (@(posedge clk) disable iff (rst)
    (done && $past(done) && !$past(rst)) |->
      (overflows_seen == $past(overflows_seen) ||
       overflows_seen == $past(overflows_seen) + OVF_W'(1)))
    else $error("overflow count jumped");

endmodule

bind event_fifo_batch_admit_overflow evf_checker u_evf_checker (.*);
